@@ sv/gxf_packet_deframer_top_assert.svh @@
// assertion helpers for the deframer top level
`ifndef GXF_PACKET_DEFRAMER_TOP_ASSERT_SVH
`define GXF_PACKET_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication
`define GXFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GXFD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/gxfd_pkg.sv @@
`default_nettype none
package gxfd_pkg;

  localparam int NUM_STREAMS = 64;

  localparam logic [7:0] TYPE_MEDIA    = 8'hBF;
  localparam logic [7:0] TYPE_EOS      = 8'hFB;
  localparam logic [7:0] MEDIA_ID_BASE = 8'hC0;

  localparam logic [7:0] HDR_LEAD [5] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
  localparam logic [7:0] HDR_TAIL [6] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hE1, 8'hE2};

  // ceil(2^33 / 3), exact divide by three for any 32-bit value
  localparam logic [31:0] DIV3_MAGIC = 32'hAAAA_AAAB;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_FIELD  = 3'd0,
    CFG_FIELDS_FRAME = 3'd1,
    CFG_FRAME_DUR    = 3'd2,
    CFG_ENABLE_MASK  = 3'd3,
    CFG_SYNC_ENABLE  = 3'd4,
    CFG_SYNC_OFFSET  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_MEDIA   = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_SKIP    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EOS     = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [31:0] first_field_number;
    logic [1:0]  fields_per_frame;
    logic [9:0]  ticks_per_frame;
    logic [63:0] stream_enable_mask;
    logic        sync_enable;
    logic [31:0] sync_field_offset;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  media_id;
    logic [41:0] timestamp;
    logic [31:0] field_number;
    logic [7:0]  payload_byte;
    logic        first_of_packet;
    logic        last_of_packet;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage
`default_nettype wire

@@ sv/gxfd_in_if.sv @@
`default_nettype none
interface gxfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface
`default_nettype wire

@@ sv/gxfd_out_if.sv @@
`default_nettype none
interface gxfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  media_id;
  logic [41:0] timestamp;
  logic [31:0] field_number;
  logic [7:0]  payload_byte;
  logic        first_of_packet;
  logic        last_of_packet;

  modport source (output valid, output kind, output media_id, output timestamp,
                  output field_number, output payload_byte, output first_of_packet,
                  output last_of_packet, input ready);
  modport sink (input valid, input kind, input media_id, input timestamp,
                input field_number, input payload_byte, input first_of_packet,
                input last_of_packet, output ready);
endinterface
`default_nettype wire

@@ sv/gxfd_ts_unit.sv @@
`default_nettype none
module gxfd_ts_unit
  import gxfd_pkg::*;
(
  input  wire logic        clk,
  input  wire cfg_t        cfg,
  input  wire logic [31:0] field,
  output logic [31:0]      rel,
  output logic [41:0]      ts
);

  // free-running four-stage pipe: field settles long before the media header ends
  logic [31:0] rel_r, rel_d_r, quo_r;
  logic [63:0] prod_r;
  logic [41:0] ts_r;
  logic [31:0] rel_nxt, quo_nxt;
  logic [63:0] prod_nxt;
  logic [41:0] ts_nxt;

  assign rel_nxt  = field - cfg.first_field_number;
  assign prod_nxt = rel_r * DIV3_MAGIC;

  always_comb begin
    case (cfg.fields_per_frame)
      2'd2:    quo_nxt = rel_d_r >> 1;
      2'd3:    quo_nxt = {1'b0, prod_r[63:33]};
      default: quo_nxt = rel_d_r;
    endcase
  end

  assign ts_nxt = quo_r * cfg.ticks_per_frame;

  always_ff @(posedge clk) begin
    rel_r   <= rel_nxt;
    rel_d_r <= rel_r;
    prod_r  <= prod_nxt;
    quo_r   <= quo_nxt;
    ts_r    <= ts_nxt;
  end

  assign rel = rel_r;
  assign ts  = ts_r;

endmodule
`default_nettype wire

@@ sv/gxfd_parser.sv @@
`default_nettype none
module gxfd_parser
  import gxfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  gxfd_in_if.sink         in_ch,
  input  wire fifo_stat_t fifo_stat,
  output push_t           wr
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  byte_index_r, byte_index_nxt;
  logic [7:0]  packet_kind_r, packet_kind_nxt;
  logic [31:0] remaining_r, remaining_nxt;
  logic [7:0]  current_id_r, current_id_nxt;
  logic [31:0] current_field_r, current_field_nxt;
  logic [41:0] current_ts_r, current_ts_nxt;
  logic        header_bad_r, header_bad_nxt;
  logic        at_first_r, at_first_nxt;

  logic        fire;
  logic [7:0]  b;
  logic        hdr_mis;
  logic        hdr_fail;
  logic        last_hdr_byte;
  logic [31:0] rem_dec;
  logic [31:0] rel;
  logic [41:0] ts;
  logic [7:0]  rel_id;
  logic        stream_ok;
  logic        wanted;
  logic [2:0]  tail_sel;

  gxfd_ts_unit u_ts (
    .clk   (clk),
    .cfg   (cfg),
    .field (current_field_r),
    .rel   (rel),
    .ts    (ts)
  );

  assign in_ch.ready   = !fifo_stat.full;
  assign fire          = in_ch.valid && in_ch.ready;
  assign b             = in_ch.stream_byte;
  assign last_hdr_byte = (byte_index_r == 4'd15);
  assign rem_dec       = remaining_r - 32'd1;
  assign tail_sel      = 3'(byte_index_r - 4'd10);

  always_comb begin
    hdr_mis = 1'b0;
    if (byte_index_r < 4'd5) begin
      hdr_mis = (b != HDR_LEAD[byte_index_r[2:0]]);
    end else if (byte_index_r >= 4'd10) begin
      hdr_mis = (b != HDR_TAIL[tail_sel]);
    end
  end

  assign hdr_fail = header_bad_r || hdr_mis || (remaining_r < 32'd16) ||
                    ((packet_kind_r == TYPE_MEDIA) && (remaining_r < 32'd32));

  assign rel_id    = current_id_r - MEDIA_ID_BASE;
  assign stream_ok = (current_id_r >= MEDIA_ID_BASE) &&
                     ({1'b0, rel_id} < 9'(NUM_STREAMS)) &&
                     cfg.stream_enable_mask[rel_id[5:0]];
  assign wanted    = stream_ok && !(cfg.sync_enable && (rel < cfg.sync_field_offset));

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      case (phase_r)
        PH_HEADER: begin
          if (last_hdr_byte) begin
            if (hdr_fail) begin
              phase_nxt = PH_HEADER;
            end else if (packet_kind_r == TYPE_MEDIA) begin
              phase_nxt = PH_MEDIA;
            end else if ((remaining_r - 32'd16) != 32'd0) begin
              phase_nxt = PH_SKIP;
            end else begin
              phase_nxt = PH_HEADER;
            end
          end
        end
        PH_MEDIA: begin
          if (last_hdr_byte) begin
            if (remaining_r == 32'd0) begin
              phase_nxt = PH_HEADER;
            end else begin
              phase_nxt = wanted ? PH_PAYLOAD : PH_SKIP;
            end
          end
        end
        PH_PAYLOAD: begin
          if (rem_dec == 32'd0) begin
            phase_nxt = PH_HEADER;
          end
        end
        PH_SKIP: begin
          if ((remaining_r == 32'd0) || (rem_dec == 32'd0)) begin
            phase_nxt = PH_HEADER;
          end
        end
        default: phase_nxt = PH_HEADER;
      endcase
    end
  end

  // datapath and queue writes
  always_comb begin
    byte_index_nxt    = byte_index_r;
    packet_kind_nxt   = packet_kind_r;
    remaining_nxt     = remaining_r;
    current_id_nxt    = current_id_r;
    current_field_nxt = current_field_r;
    current_ts_nxt    = current_ts_r;
    header_bad_nxt    = header_bad_r;
    at_first_nxt      = at_first_r;

    wr.push                 = 1'b0;
    wr.item.kind            = KIND_PAYLOAD;
    wr.item.media_id        = current_id_r;
    wr.item.timestamp       = current_ts_r;
    wr.item.field_number    = current_field_r;
    wr.item.payload_byte    = b;
    wr.item.first_of_packet = at_first_r;
    wr.item.last_of_packet  = (rem_dec == 32'd0);

    if (fire) begin
      case (phase_r)
        PH_HEADER: begin
          header_bad_nxt = header_bad_r || hdr_mis;
          if (byte_index_r == 4'd5) begin
            packet_kind_nxt = b;
          end
          if ((byte_index_r >= 4'd6) && (byte_index_r <= 4'd9)) begin
            remaining_nxt = {remaining_r[23:0], b};
          end
          if (!last_hdr_byte) begin
            byte_index_nxt = byte_index_r + 4'd1;
          end else begin
            byte_index_nxt = 4'd0;
            if (hdr_fail) begin
              header_bad_nxt = 1'b0;
              remaining_nxt  = 32'd0;
              wr.push        = 1'b1;
              wr.item.kind   = KIND_ERROR;
            end else if (packet_kind_r == TYPE_MEDIA) begin
              remaining_nxt = remaining_r - 32'd32;
            end else begin
              remaining_nxt = remaining_r - 32'd16;
              if (packet_kind_r == TYPE_EOS) begin
                wr.push      = 1'b1;
                wr.item.kind = KIND_EOS;
              end
            end
          end
        end
        PH_MEDIA: begin
          if (byte_index_r == 4'd1) begin
            current_id_nxt = b;
          end
          if ((byte_index_r >= 4'd2) && (byte_index_r <= 4'd5)) begin
            current_field_nxt = {current_field_r[23:0], b};
          end
          if (!last_hdr_byte) begin
            byte_index_nxt = byte_index_r + 4'd1;
          end else begin
            byte_index_nxt = 4'd0;
            current_ts_nxt = ts;
            at_first_nxt   = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          remaining_nxt = rem_dec;
          wr.push       = 1'b1;
          at_first_nxt  = 1'b0;
        end
        PH_SKIP: begin
          if (remaining_r != 32'd0) begin
            remaining_nxt = rem_dec;
          end
          byte_index_nxt = 4'd0;
        end
        default: byte_index_nxt = 4'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HEADER;
      byte_index_r    <= 4'd0;
      packet_kind_r   <= 8'd0;
      remaining_r     <= 32'd0;
      current_id_r    <= 8'd0;
      current_field_r <= 32'd0;
      current_ts_r    <= 42'd0;
      header_bad_r    <= 1'b0;
      at_first_r      <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      byte_index_r    <= byte_index_nxt;
      packet_kind_r   <= packet_kind_nxt;
      remaining_r     <= remaining_nxt;
      current_id_r    <= current_id_nxt;
      current_field_r <= current_field_nxt;
      current_ts_r    <= current_ts_nxt;
      header_bad_r    <= header_bad_nxt;
      at_first_r      <= at_first_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/gxfd_fifo.sv @@
`default_nettype none
module gxfd_fifo
  import gxfd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t wr,
  input  wire logic  pop,
  output item_t      head,
  output fifo_stat_t stat
);

  item_t              slots_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;

  assign stat.full  = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head       = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr.push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    case ({wr.push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.push) begin
      slots_r[wr_ptr_r] <= wr.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/gxfd_emit.sv @@
`default_nettype none
module gxfd_emit
  import gxfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire item_t      head,
  input  wire fifo_stat_t fifo_stat,
  output logic            pop,
  gxfd_out_if.source      out_ch
);

  logic  out_valid_r, out_valid_nxt;
  item_t item_r, item_nxt;

  assign pop = !fifo_stat.empty && (!out_valid_r || out_ch.ready);

  // status requests carry only their kind
  always_comb begin
    item_nxt = head;
    if (head.kind != KIND_PAYLOAD) begin
      item_nxt.media_id        = 8'd0;
      item_nxt.timestamp       = 42'd0;
      item_nxt.field_number    = 32'd0;
      item_nxt.payload_byte    = 8'd0;
      item_nxt.first_of_packet = 1'b0;
      item_nxt.last_of_packet  = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.kind            = item_r.kind;
  assign out_ch.media_id        = item_r.media_id;
  assign out_ch.timestamp       = item_r.timestamp;
  assign out_ch.field_number    = item_r.field_number;
  assign out_ch.payload_byte    = item_r.payload_byte;
  assign out_ch.first_of_packet = item_r.first_of_packet;
  assign out_ch.last_of_packet  = item_r.last_of_packet;

endmodule
`default_nettype wire

@@ sv/gxf_packet_deframer_top.sv @@
// path: a byte that yields a request is written to the queue, then registered in the output stage for out
// throughput: one byte per cycle; in_ch.ready drops only while the 4-entry queue is full
// timestamp: field register plus four pipe stages, done well before the media header ends
// reset: synchronous, active low; clears parser state and config to defaults, no clearing pass
`default_nettype none
`include "gxf_packet_deframer_top_assert.svh"
module gxf_packet_deframer_top
  import gxfd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  gxfd_in_if.sink                    in_ch,
  gxfd_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg_r, cfg_nxt;
  push_t      wr;
  item_t      head;
  fifo_stat_t fifo_stat;
  logic       pop;
  logic       status_clear;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FIRST_FIELD:  cfg_nxt.first_field_number = cfg_data[31:0];
        CFG_FIELDS_FRAME: cfg_nxt.fields_per_frame   = cfg_data[1:0];
        CFG_FRAME_DUR:    cfg_nxt.ticks_per_frame    = cfg_data[9:0];
        CFG_ENABLE_MASK:  cfg_nxt.stream_enable_mask = cfg_data[63:0];
        CFG_SYNC_ENABLE:  cfg_nxt.sync_enable        = cfg_data[0];
        CFG_SYNC_OFFSET:  cfg_nxt.sync_field_offset  = cfg_data[31:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_field_number <= 32'd0;
      cfg_r.fields_per_frame   <= 2'd1;
      cfg_r.ticks_per_frame    <= 10'd1;
      cfg_r.stream_enable_mask <= 64'd0;
      cfg_r.sync_enable        <= 1'b0;
      cfg_r.sync_field_offset  <= 32'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gxfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .fifo_stat (fifo_stat),
    .wr        (wr)
  );

  gxfd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .pop   (pop),
    .head  (head),
    .stat  (fifo_stat)
  );

  gxfd_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .fifo_stat (fifo_stat),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  assign status_clear = (out_ch.media_id == 8'd0) && (out_ch.timestamp == 42'd0) &&
                        (out_ch.field_number == 32'd0) && (out_ch.payload_byte == 8'd0) &&
                        !out_ch.first_of_packet && !out_ch.last_of_packet;

  `GXFD_ASSERT_NOW(a_no_push_when_full, wr.push, !fifo_stat.full, "push into full queue")
  `GXFD_ASSERT_NXT(a_push_lands, wr.push, !fifo_stat.empty, "pushed request missing")
  `GXFD_ASSERT_NOW(a_status_zeroed, out_ch.valid && (out_ch.kind != KIND_PAYLOAD), status_clear, "status request carries payload fields")

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import gxfd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_BYTES = 250;
  // fixed bytes of a packet header, type and length positions are filled per packet
  localparam logic [0:15][7:0] HEADER_FRAME = {
    8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE1, 8'hE2
  };

  class deframe_tracker;
    cfg_t        cfg;
    phase_t      phase;
    logic [4:0]  byte_idx;
    logic [7:0]  pkt_type;
    logic [31:0] remaining;
    logic [7:0]  cur_id;
    logic [31:0] cur_field;
    logic [41:0] cur_ts;
    bit          wanted;
    bit          hdr_bad;
    bit          at_first;
    item_t       outstanding[$];
    int          errors;

    function new();
      cfg.first_field_number = '0;
      cfg.fields_per_frame   = 2'd1;
      cfg.ticks_per_frame    = 10'd1;
      cfg.stream_enable_mask = '0;
      cfg.sync_enable        = 1'b0;
      cfg.sync_field_offset  = '0;
      phase     = PH_HEADER;
      byte_idx  = '0;
      pkt_type  = '0;
      remaining = '0;
      cur_id    = '0;
      cur_field = '0;
      cur_ts    = '0;
      wanted    = 0;
      hdr_bad   = 0;
      at_first  = 0;
      errors    = 0;
    endfunction

    function void take_byte(logic [7:0] b);
      item_t       r;
      logic [3:0]  idx;
      logic [31:0] rel;
      logic [31:0] fpf;
      logic [63:0] prod;
      logic [7:0]  slot;
      r = '0;
      idx = byte_idx[3:0];
      case (phase)
        PH_HEADER: begin
          if (idx < 5 || idx >= 10) begin
            if (b != HEADER_FRAME[idx]) hdr_bad = 1;
          end else if (idx == 5) begin
            pkt_type = b;
          end else begin
            remaining = {remaining[23:0], b};
          end
          if (idx < 15) begin
            byte_idx = idx + 1;
          end else begin
            byte_idx = '0;
            if (hdr_bad || remaining < 16 || (pkt_type == TYPE_MEDIA && remaining < 32)) begin
              hdr_bad = 0;
              remaining = '0;
              phase = PH_HEADER;
              r.kind = KIND_ERROR;
              outstanding.push_back(r);
            end else if (pkt_type == TYPE_MEDIA) begin
              remaining = remaining - 32;
              phase = PH_MEDIA;
            end else begin
              remaining = remaining - 16;
              phase = (remaining != 0) ? PH_SKIP : PH_HEADER;
              if (pkt_type == TYPE_EOS) begin
                r.kind = KIND_EOS;
                outstanding.push_back(r);
              end
            end
          end
        end
        PH_MEDIA: begin
          if (idx == 1) cur_id = b;
          else if (idx >= 2 && idx <= 5) cur_field = {cur_field[23:0], b};
          if (idx < 15) begin
            byte_idx = idx + 1;
          end else begin
            byte_idx = '0;
            rel = cur_field - cfg.first_field_number;
            fpf = (cfg.fields_per_frame == 0) ? 32'd1 : 32'(cfg.fields_per_frame);
            prod = 64'(rel / fpf) * 64'(cfg.ticks_per_frame);
            cur_ts = prod[41:0];
            slot = cur_id - MEDIA_ID_BASE;
            wanted = (cur_id >= MEDIA_ID_BASE) && (slot < NUM_STREAMS) &&
                     cfg.stream_enable_mask[slot[5:0]];
            if (cfg.sync_enable && rel < cfg.sync_field_offset) wanted = 0;
            at_first = 1;
            if (remaining == 0) phase = PH_HEADER;
            else phase = wanted ? PH_PAYLOAD : PH_SKIP;
          end
        end
        PH_PAYLOAD: begin
          remaining = remaining - 1;
          r.kind            = KIND_PAYLOAD;
          r.media_id        = cur_id;
          r.timestamp       = cur_ts;
          r.field_number    = cur_field;
          r.payload_byte    = b;
          r.first_of_packet = at_first;
          r.last_of_packet  = (remaining == 0);
          at_first = 0;
          if (remaining == 0) phase = PH_HEADER;
          outstanding.push_back(r);
        end
        default: begin
          if (remaining > 0) remaining = remaining - 1;
          if (remaining == 0) phase = PH_HEADER;
          byte_idx = '0;
        end
      endcase
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(item_t got);
      item_t want;
      if (outstanding.size() == 0) begin
        $error("unexpected request of kind %0d", got.kind);
        errors++;
        return;
      end
      want = outstanding.pop_front();
      check_field("kind", 64'(want.kind), 64'(got.kind));
      check_field("media_id", 64'(want.media_id), 64'(got.media_id));
      check_field("timestamp", 64'(want.timestamp), 64'(got.timestamp));
      check_field("field_number", 64'(want.field_number), 64'(got.field_number));
      check_field("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
      check_field("first_of_packet", 64'(want.first_of_packet), 64'(got.first_of_packet));
      check_field("last_of_packet", 64'(want.last_of_packet), 64'(got.last_of_packet));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gxfd_in_if  in_ch ();
  gxfd_out_if out_ch ();

  gxf_packet_deframer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  deframe_tracker tracker;
  logic [7:0]     frame_bytes[$];
  bit             tx_stall_on = 1;
  bit             rx_stall_on = 1;
  int             cycle_count = 0;
  int             phase_bytes = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= rx_stall_on ? ($urandom_range(99) >= 12) : 1'b1;
  end

  always @(posedge clk) begin : watch
    item_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind            = kind_t'(out_ch.kind);
        got.media_id        = out_ch.media_id;
        got.timestamp       = out_ch.timestamp;
        got.field_number    = out_ch.field_number;
        got.payload_byte    = out_ch.payload_byte;
        got.first_of_packet = out_ch.first_of_packet;
        got.last_of_packet  = out_ch.last_of_packet;
        tracker.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) tracker.take_byte(in_ch.stream_byte);
    end
  end

  function automatic cfg_t make_cfg(logic [31:0] first, logic [1:0] fpf, logic [9:0] dur,
                                    logic [63:0] mask, logic sync, logic [31:0] offset);
    cfg_t c;
    c.first_field_number = first;
    c.fields_per_frame   = fpf;
    c.ticks_per_frame    = dur;
    c.stream_enable_mask = mask;
    c.sync_enable        = sync;
    c.sync_field_offset  = offset;
    return c;
  endfunction

  // called at a falling edge, returns at the falling edge after the byte is taken
  task automatic send_byte(logic [7:0] b);
    while (tx_stall_on && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.stream_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    phase_bytes++;
  endtask

  task automatic flush_bytes();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    frame_bytes.delete();
  endtask

  task automatic put_reg(cfg_idx_t idx, logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
  endtask

  task automatic load_config(cfg_t c);
    put_reg(CFG_FIRST_FIELD, 64'(c.first_field_number));
    put_reg(CFG_FIELDS_FRAME, 64'(c.fields_per_frame));
    put_reg(CFG_FRAME_DUR, 64'(c.ticks_per_frame));
    put_reg(CFG_ENABLE_MASK, c.stream_enable_mask);
    put_reg(CFG_SYNC_ENABLE, 64'(c.sync_enable));
    put_reg(CFG_SYNC_OFFSET, 64'(c.sync_field_offset));
    cfg_we <= 1'b0;
    tracker.cfg = c;
    phase_bytes = 0;
  endtask

  // hold the sender until every request has drained, then let the parser go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.outstanding.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic push_header(logic [7:0] ptype, logic [31:0] len);
    for (int i = 0; i < 16; i++) begin
      if (i == 5) frame_bytes.push_back(ptype);
      else if (i >= 6 && i <= 9) frame_bytes.push_back(len[8*(9-i) +: 8]);
      else frame_bytes.push_back(HEADER_FRAME[i]);
    end
  endtask

  task automatic media_packet(logic [7:0] id, logic [31:0] field, int n);
    push_header(TYPE_MEDIA, 32 + n);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(id);
    for (int i = 3; i >= 0; i--) frame_bytes.push_back(field[8*i +: 8]);
    // information, timeline field, flags, reserved
    repeat (10) frame_bytes.push_back(8'($urandom));
    repeat (n) frame_bytes.push_back(8'($urandom));
    flush_bytes();
  endtask

  task automatic plain_packet(logic [7:0] ptype, int body);
    push_header(ptype, 16 + body);
    repeat (body) frame_bytes.push_back(8'($urandom));
    flush_bytes();
  endtask

  task automatic bad_header();
    int pick;
    int pos;
    push_header(8'($urandom), $urandom);
    pick = $urandom_range(10);
    pos = (pick < 5) ? pick : pick + 5;
    frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(255, 1));
    flush_bytes();
  endtask

  task automatic random_packet();
    int          roll;
    logic [7:0]  id;
    logic [31:0] field;
    logic [7:0]  ptype;
    roll = $urandom_range(99);
    if (roll < 68) begin
      id = ($urandom_range(99) < 85) ? MEDIA_ID_BASE + 8'($urandom_range(63))
                                     : 8'($urandom_range(255));
      field = ($urandom_range(99) < 85) ?
              tracker.cfg.first_field_number + $urandom_range(12) : $urandom;
      media_packet(id, field, ($urandom_range(99) < 90) ? $urandom_range(10)
                                                        : $urandom_range(48, 11));
    end else if (roll < 76) begin
      plain_packet(TYPE_EOS, ($urandom_range(1) == 0) ? 0 : $urandom_range(6));
    end else if (roll < 83) begin
      do ptype = 8'($urandom); while (ptype == TYPE_MEDIA || ptype == TYPE_EOS);
      plain_packet(ptype, $urandom_range(20));
    end else if (roll < 89) begin
      bad_header();
    end else if (roll < 94) begin
      if ($urandom_range(1) == 0) push_header(8'($urandom), $urandom_range(15));
      else push_header(TYPE_MEDIA, $urandom_range(31, 16));
      flush_bytes();
    end else begin
      // whole header's worth of noise keeps the parser aligned afterwards
      repeat (16) frame_bytes.push_back(8'($urandom));
      flush_bytes();
    end
  endtask

  initial begin
    tracker = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.stream_byte = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_FIRST_FIELD;
    cfg_data = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    load_config(make_cfg(32'h10, 2'd2, 10'd1001, '1, 1'b1, 32'd2));
    media_packet(MEDIA_ID_BASE, 32'h13, 3);
    media_packet(MEDIA_ID_BASE + 8'd63, 32'h14, 0);  // empty payload
    media_packet(MEDIA_ID_BASE + 8'd5, 32'h11, 2);   // ahead of sync field
    media_packet(8'h12, 32'h16, 2);                   // id below stream range
    media_packet(MEDIA_ID_BASE + 8'd1, 32'h0F, 2);   // field below first, wraps
    plain_packet(TYPE_EOS, 0);
    plain_packet(TYPE_EOS, 4);
    plain_packet(8'h01, 2);
    bad_header();
    bad_header();
    push_header(8'h00, 32'd15);
    flush_bytes();
    push_header(TYPE_MEDIA, 32'd31);
    flush_bytes();
    settle();

    load_config(make_cfg('1, 2'd0, 10'd0, 64'h8000_0000_0000_0001, 1'b0, '1));
    media_packet(MEDIA_ID_BASE + 8'd63, 32'hFFFF_FFFE, 2);
    media_packet(MEDIA_ID_BASE, 32'h0, 1);
    media_packet(MEDIA_ID_BASE + 8'd2, 32'h0, 1);    // stream disabled
    settle();

    load_config(make_cfg('0, 2'd3, 10'd1023, '1, 1'b1, '1));
    media_packet(MEDIA_ID_BASE + 8'd7, 32'hFFFF_FFFF, 2);
    media_packet(MEDIA_ID_BASE + 8'd7, 32'h5, 2);
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: load_config(make_cfg($urandom, 2'd1, 10'd1, '1, 1'b0, '0));
        1: load_config(make_cfg($urandom, 2'd3, 10'd1023, {$urandom, $urandom}, 1'b1,
                                $urandom_range(6)));
        2: load_config(make_cfg($urandom, 2'd0, 10'd0, '0, 1'b1, '1));
        3: load_config(make_cfg($urandom, 2'd2, 10'd1001, {$urandom, $urandom}, 1'b1, '0));
        default: load_config(make_cfg($urandom, 2'($urandom_range(3)),
                                      10'($urandom_range(1023)), {$urandom, $urandom},
                                      1'($urandom_range(1)), $urandom_range(4)));
      endcase
      // one phase runs without gaps on either side
      tx_stall_on = (ph != 3);
      rx_stall_on = (ph != 3);
      while (phase_bytes < PHASE_BYTES) random_packet();
      settle();
    end

    repeat (10) @(negedge clk);
    if (tracker.errors == 0 && tracker.outstanding.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ gxf_packet_deframer_top.f @@
+incdir+sv
sv/gxfd_pkg.sv
sv/gxfd_in_if.sv
sv/gxfd_out_if.sv
sv/gxfd_ts_unit.sv
sv/gxfd_parser.sv
sv/gxfd_fifo.sv
sv/gxfd_emit.sv
sv/gxf_packet_deframer_top.sv
verif/tb.sv
